// ===== design/mlfp_pkg.sv =====
// ----------------------------------------------------------------------------
// mlfp_pkg
// shared types and constants of the motor link frame parser
// ----------------------------------------------------------------------------
package mlfp_pkg;

   localparam int MAX_PAYLOAD = 64;

   localparam int BYTE_W   = 8;
   localparam int POS_W    = 7;
   localparam int STATUS_W = 3;
   localparam int CNT_W    = $clog2(MAX_PAYLOAD + 1);
   localparam int CMP_W    = (CNT_W > BYTE_W) ? CNT_W : BYTE_W;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [BYTE_W-1:0] OWN_ID_RST       = 8'd184;
   localparam logic [BYTE_W-1:0] SENDER_ID_A_RST  = 8'd183;
   localparam logic [BYTE_W-1:0] SENDER_ID_B_RST  = 8'd172;
   localparam logic [BYTE_W-1:0] BROADCAST_ID_RST = 8'd254;
   localparam logic [BYTE_W-1:0] UNICAST_ID       = 8'd1;

   typedef enum logic [1:0] {
      REG_OWN_ID       = 2'd0,
      REG_SENDER_ID_A  = 2'd1,
      REG_SENDER_ID_B  = 2'd2,
      REG_BROADCAST_ID = 2'd3
   } reg_index_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_IGNORED  = 3'd0,
      STATUS_ACCEPTED = 3'd1,
      STATUS_GOOD     = 3'd2,
      STATUS_CKERR    = 3'd3,
      STATUS_REJECT   = 3'd4,
      STATUS_OVERFLOW = 3'd5
   } status_type;

   typedef struct packed {
      logic [BYTE_W-1:0] byte_out;
      logic [POS_W-1:0]  position;
      status_type        status;
      logic              frame_end;
   } result_type;

endpackage

// ===== design/motor_link_frame_parser_core.sv =====
// ----------------------------------------------------------------------------
// motor_link_frame_parser_core
// receive-side deframer for a serial motor link, one byte per word
// ----------------------------------------------------------------------------
// Each word on req_ carries one received serial byte. The parser hunts for a
// frame laid out as receiver id (own_id), sender id (sender_id_a or
// sender_id_b), target id (1 or broadcast_id), packet id, payload length,
// payload and checksum, keeping an 8-bit byte sum over the frame; the frame
// is good when the sum including the checksum byte is zero. Every byte comes
// back on rsp_ with its frame position (0 while hunting, modulo 128), a
// status and a frame_end flag for the byte that ends or aborts a frame. A
// zero length still takes one payload byte, and a frame whose payload
// count reaches MAX_PAYLOAD is aborted with the overflow status. The parser
// state is updated in the cycle the word is accepted and the result lands
// in an output register, backed by a one-word skid register, so a new word
// is taken every cycle while rsp_ready is held and one more word is still
// taken when the output stalls. The four id registers sit at byte addresses
// 0, 4, 8 and 12 of the csr_ port.
// ----------------------------------------------------------------------------
module motor_link_frame_parser_core (
   input  logic                              clock,
   input  logic                              reset,
   // byte input
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [mlfp_pkg::BYTE_W-1:0]       req_rx_byte,
   // result output
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [mlfp_pkg::BYTE_W-1:0]       rsp_byte_out,
   output logic [mlfp_pkg::POS_W-1:0]        rsp_position,
   output logic [mlfp_pkg::STATUS_W-1:0]     rsp_status,
   output logic                              rsp_frame_end,
   // register port
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [mlfp_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [mlfp_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [mlfp_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);
   import mlfp_pkg::*;

   // parser phases, one per frame field
   typedef enum logic [2:0] {
      STEP_HUNT     = 3'd0,
      STEP_SENDER   = 3'd1,
      STEP_TARGET   = 3'd2,
      STEP_PACKET   = 3'd3,
      STEP_LENGTH   = 3'd4,
      STEP_PAYLOAD  = 3'd5,
      STEP_CHECKSUM = 3'd6
   } step_type;

   // id registers
   logic [BYTE_W-1:0] own_id_ff, sender_id_a_ff, sender_id_b_ff, broadcast_id_ff;
   reg_index_type     csr_index;
   logic              csr_write;

   // parser state
   step_type          step_ff, step_in;
   logic [BYTE_W-1:0] sum_ff, sum_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [BYTE_W-1:0] length_ff, length_in;
   logic [POS_W-1:0]  pos_ff, pos_in;

   // output register and skid register
   result_type        out_ff, skid_ff, result;
   logic              out_valid_ff, skid_valid_ff;

   logic              accept;
   logic              out_take;
   logic [BYTE_W-1:0] sum_add;
   logic [POS_W-1:0]  pos_inc;
   logic [CNT_W-1:0]  count_inc;

   // ------------------------------------------------------------------------
   // register port
   // ------------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_index  = reg_index_type'(csr_paddr[3:2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         own_id_ff       <= OWN_ID_RST;
         sender_id_a_ff  <= SENDER_ID_A_RST;
         sender_id_b_ff  <= SENDER_ID_B_RST;
         broadcast_id_ff <= BROADCAST_ID_RST;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_OWN_ID:       own_id_ff       <= csr_pwdata[BYTE_W-1:0];
            REG_SENDER_ID_A:  sender_id_a_ff  <= csr_pwdata[BYTE_W-1:0];
            REG_SENDER_ID_B:  sender_id_b_ff  <= csr_pwdata[BYTE_W-1:0];
            REG_BROADCAST_ID: broadcast_id_ff <= csr_pwdata[BYTE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      csr_prdata = '0;
      unique case (csr_index)
         REG_OWN_ID:       csr_prdata[BYTE_W-1:0] = own_id_ff;
         REG_SENDER_ID_A:  csr_prdata[BYTE_W-1:0] = sender_id_a_ff;
         REG_SENDER_ID_B:  csr_prdata[BYTE_W-1:0] = sender_id_b_ff;
         REG_BROADCAST_ID: csr_prdata[BYTE_W-1:0] = broadcast_id_ff;
         default: ;
      endcase
   end

   // ------------------------------------------------------------------------
   // handshakes
   // ------------------------------------------------------------------------
   // a word is taken whenever the skid register is free
   assign req_ready = !skid_valid_ff;
   assign accept    = req_valid && req_ready;
   assign out_take  = out_valid_ff && rsp_ready;

   // ------------------------------------------------------------------------
   // per-byte parser step
   // ------------------------------------------------------------------------
   assign sum_add   = sum_ff + req_rx_byte;
   assign pos_inc   = pos_ff + 1'b1;
   assign count_inc = count_ff + 1'b1;

   always_comb begin
      step_in   = step_ff;
      sum_in    = sum_add;
      count_in  = count_ff;
      length_in = length_ff;
      pos_in    = pos_ff;

      result.byte_out  = req_rx_byte;
      result.position  = pos_ff;
      result.status    = STATUS_ACCEPTED;
      result.frame_end = 1'b0;

      unique case (step_ff)
         STEP_HUNT: begin
            result.position = '0;
            sum_in          = sum_ff;
            if (req_rx_byte == own_id_ff) begin
               sum_in  = req_rx_byte;
               pos_in  = POS_W'(1);
               step_in = STEP_SENDER;
            end else begin
               result.status = STATUS_IGNORED;
            end
         end
         STEP_SENDER: begin
            if (req_rx_byte == sender_id_a_ff || req_rx_byte == sender_id_b_ff) begin
               pos_in  = pos_inc;
               step_in = STEP_TARGET;
            end else begin
               // rejected byte is not retried as a start byte
               sum_in           = sum_ff;
               step_in          = STEP_HUNT;
               result.status    = STATUS_REJECT;
               result.frame_end = 1'b1;
            end
         end
         STEP_TARGET: begin
            if (req_rx_byte == UNICAST_ID || req_rx_byte == broadcast_id_ff) begin
               pos_in  = pos_inc;
               step_in = STEP_PACKET;
            end else begin
               sum_in           = sum_ff;
               step_in          = STEP_HUNT;
               result.status    = STATUS_REJECT;
               result.frame_end = 1'b1;
            end
         end
         STEP_PACKET: begin
            pos_in  = pos_inc;
            step_in = STEP_LENGTH;
         end
         STEP_LENGTH: begin
            pos_in    = pos_inc;
            length_in = req_rx_byte;
            count_in  = '0;
            step_in   = STEP_PAYLOAD;
         end
         STEP_PAYLOAD: begin
            pos_in   = pos_inc;
            count_in = count_inc;
            if (CMP_W'(count_inc) >= CMP_W'(MAX_PAYLOAD)) begin
               // payload too long, abort and hunt again
               step_in          = STEP_HUNT;
               result.status    = STATUS_OVERFLOW;
               result.frame_end = 1'b1;
            end else if (CMP_W'(count_inc) >= CMP_W'(length_ff)) begin
               // zero length lands here too, after one payload byte
               step_in = STEP_CHECKSUM;
            end
         end
         STEP_CHECKSUM: begin
            step_in          = STEP_HUNT;
            result.status    = (sum_add == '0) ? STATUS_GOOD : STATUS_CKERR;
            result.frame_end = 1'b1;
         end
         default: begin
            // unused step code: ignore the byte and hunt again
            sum_in          = sum_ff;
            step_in         = STEP_HUNT;
            result.position = '0;
            result.status   = STATUS_IGNORED;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff   <= STEP_HUNT;
         sum_ff    <= '0;
         count_ff  <= '0;
         length_ff <= '0;
         pos_ff    <= '0;
      end else if (accept) begin
         step_ff   <= step_in;
         sum_ff    <= sum_in;
         count_ff  <= count_in;
         length_ff <= length_in;
         pos_ff    <= pos_in;
      end
   end

   // ------------------------------------------------------------------------
   // output register with skid
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         // no word is taken while the skid register is full
         if (out_take) begin
            out_ff        <= skid_ff;
            skid_valid_ff <= 1'b0;
         end
      end else if (accept) begin
         if (!out_valid_ff || out_take) begin
            out_ff       <= result;
            out_valid_ff <= 1'b1;
         end else begin
            skid_ff       <= result;
            skid_valid_ff <= 1'b1;
         end
      end else if (out_take) begin
         out_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_byte_out  = out_ff.byte_out;
   assign rsp_position  = out_ff.position;
   assign rsp_status    = out_ff.status;
   assign rsp_frame_end = out_ff.frame_end;

`ifndef SYNTHESIS
   // skid register only fills behind a waiting result
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid word without output word");

   // frame end only with a terminating status
   a_end_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_end |->
         rsp_status != STATUS_ACCEPTED && rsp_status != STATUS_IGNORED)
      else $error("frame end with non-terminating status");

   // ignored bytes sit at position zero
   a_ignored_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_IGNORED |-> rsp_position == '0)
      else $error("ignored byte with nonzero position");

   // a terminating byte sends the parser back to hunting
   a_end_to_hunt: assert property (@(posedge clock) disable iff (reset)
      accept && result.frame_end |=> step_ff == STEP_HUNT)
      else $error("parser not hunting after frame end");

   // a stalled output never drops the word behind it
   a_no_loss: assert property (@(posedge clock) disable iff (reset)
      accept && out_valid_ff && !rsp_ready |=> skid_valid_ff)
      else $error("word lost on stalled output");
`endif

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the motor link frame parser core
// ----------------------------------------------------------------------------
// A queue of received bytes feeds the req_ channel. The bench starts with a
// short directed burst, then sends mostly well-formed frames with random
// content and lengths, mixed with line noise and broken headers. Every
// accepted word goes through a behavioral parser kept in this file, and
// each rsp_ word is checked field by field against the oldest prediction.
// The run steps through several id register settings and several idle and
// stall patterns, and reads back the registers after each setting.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import mlfp_pkg::*;

   // parser steps of the behavioral model
   typedef enum logic [2:0] {
      HUNT, SENDER, TARGET, PACKET_ID, LENGTH, PAYLOAD, CHECKSUM
   } parse_step_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [BYTE_W-1:0]     req_rx_byte = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [BYTE_W-1:0]     rsp_byte_out;
   logic [POS_W-1:0]      rsp_position;
   logic [STATUS_W-1:0]   rsp_status;
   logic                  rsp_frame_end;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   motor_link_frame_parser_core DUT (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_rx_byte   (req_rx_byte),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_byte_out  (rsp_byte_out),
      .rsp_position  (rsp_position),
      .rsp_status    (rsp_status),
      .rsp_frame_end (rsp_frame_end),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // bytes waiting to go out on req_, and parser echoes waiting on rsp_
   logic [BYTE_W-1:0] rx_stream[$];
   result_type        parsed_echoes[$];

   // idle percentages of the current phase
   int gap_pct   = 0;
   int stall_pct = 0;

   // our copy of the id registers
   logic [BYTE_W-1:0] own_id_reg    = OWN_ID_RST;
   logic [BYTE_W-1:0] sender_a_reg  = SENDER_ID_A_RST;
   logic [BYTE_W-1:0] sender_b_reg  = SENDER_ID_B_RST;
   logic [BYTE_W-1:0] broadcast_reg = BROADCAST_ID_RST;

   // parser state of the model
   parse_step_type    step_q = HUNT;
   logic [BYTE_W-1:0] byte_sum = '0;
   int                payload_taken = 0;
   logic [BYTE_W-1:0] payload_len = '0;
   int                frame_pos = 0;

   // run statistics
   int mismatch_count = 0;
   int words_taken    = 0;
   int good_frames    = 0;
   int bad_checksums  = 0;
   int header_rejects = 0;
   int overflow_aborts = 0;

   // one mismatch line, printing capped so a broken core cannot flood the log
   task automatic report_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= 100) $display("%0t ns: mismatch: %s", $time, msg);
   endtask

   task automatic check_field(input string name, input int got, input int want);
      if (got != want)
         report_mismatch($sformatf("%s got %0d, want %0d", name, got, want));
   endtask

   // behavioral parser: advances the model by one received byte
   function automatic result_type parse_byte(input logic [BYTE_W-1:0] rx);
      result_type echo;
      echo.byte_out  = rx;
      echo.position  = frame_pos[POS_W-1:0];   // wide positions wrap at 128
      echo.status    = STATUS_ACCEPTED;
      echo.frame_end = 1'b0;
      case (step_q)
         HUNT: begin
            echo.position = '0;
            if (rx == own_id_reg) begin
               byte_sum  = rx;
               frame_pos = 1;
               step_q    = SENDER;
            end else begin
               echo.status = STATUS_IGNORED;
            end
         end
         SENDER, TARGET: begin
            if ((step_q == SENDER && (rx == sender_a_reg || rx == sender_b_reg)) ||
                (step_q == TARGET && (rx == UNICAST_ID || rx == broadcast_reg))) begin
               byte_sum  = byte_sum + rx;
               frame_pos = frame_pos + 1;
               step_q    = (step_q == SENDER) ? TARGET : PACKET_ID;
            end else begin
               // the rejected byte is not retried as a start byte
               step_q         = HUNT;
               echo.status    = STATUS_REJECT;
               echo.frame_end = 1'b1;
            end
         end
         PACKET_ID: begin
            byte_sum  = byte_sum + rx;
            frame_pos = frame_pos + 1;
            step_q    = LENGTH;
         end
         LENGTH: begin
            byte_sum      = byte_sum + rx;
            frame_pos     = frame_pos + 1;
            payload_len   = rx;
            payload_taken = 0;
            step_q        = PAYLOAD;
         end
         PAYLOAD: begin
            // a zero length still takes one payload byte
            byte_sum      = byte_sum + rx;
            frame_pos     = frame_pos + 1;
            payload_taken = payload_taken + 1;
            if (payload_taken >= MAX_PAYLOAD) begin
               step_q         = HUNT;
               echo.status    = STATUS_OVERFLOW;
               echo.frame_end = 1'b1;
            end else if (payload_taken >= int'(payload_len)) begin
               step_q = CHECKSUM;
            end
         end
         CHECKSUM: begin
            byte_sum       = byte_sum + rx;
            step_q         = HUNT;
            echo.status    = (byte_sum == '0) ? STATUS_GOOD : STATUS_CKERR;
            echo.frame_end = 1'b1;
         end
         default: begin
            step_q        = HUNT;
            echo.position = '0;
            echo.status   = STATUS_IGNORED;
         end
      endcase
      return echo;
   endfunction

   // byte driver: takes the next byte when the slot is free, with random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (rx_stream.size() > 0 && $urandom_range(99) >= gap_pct) begin
            req_valid   <= 1'b1;
            req_rx_byte <= rx_stream.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result side back-pressure
   always @(posedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else       rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   // monitor: predict on every accepted byte, check every accepted result
   always @(posedge clock) begin
      result_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            parsed_echoes.push_back(parse_byte(req_rx_byte));
            words_taken++;
         end
         if (rsp_valid && rsp_ready) begin
            if (parsed_echoes.size() == 0) begin
               report_mismatch($sformatf("result byte %0d with nothing pending",
                                         rsp_byte_out));
            end else begin
               want = parsed_echoes.pop_front();
               check_field("byte_out", rsp_byte_out, want.byte_out);
               check_field("position", rsp_position, want.position);
               check_field("status", rsp_status, want.status);
               check_field("frame_end", rsp_frame_end, want.frame_end);
               case (want.status)
                  STATUS_GOOD:     good_frames++;
                  STATUS_CKERR:    bad_checksums++;
                  STATUS_REJECT:   header_rejects++;
                  STATUS_OVERFLOW: overflow_aborts++;
                  default: ;
               endcase
            end
         end
      end
   end

   // register write: setup cycle, then access cycle; written at the access edge
   task automatic csr_write(input reg_index_type idx, input logic [BYTE_W-1:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         REG_OWN_ID:       own_id_reg    = value;
         REG_SENDER_ID_A:  sender_a_reg  = value;
         REG_SENDER_ID_B:  sender_b_reg  = value;
         REG_BROADCAST_ID: broadcast_reg = value;
      endcase
      @(negedge clock);
   endtask

   // register read, data sampled in the middle of the access cycle
   task automatic csr_check(input reg_index_type idx, input logic [BYTE_W-1:0] want);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      if (csr_prdata[BYTE_W-1:0] !== want)
         report_mismatch($sformatf("read of %s got %0d, want %0d",
                                   idx.name(), csr_prdata[BYTE_W-1:0], want));
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
   endtask

   // wait until every queued byte went out and every echo came back
   task automatic drain();
      while (rx_stream.size() > 0 || req_valid || parsed_echoes.size() > 0)
         @(negedge clock);
   endtask

   // one complete frame; an over-long payload ends in an abort, no checksum
   task automatic queue_frame(input int length, input bit corrupt);
      logic [BYTE_W-1:0] frame[$];
      logic [BYTE_W-1:0] sum;
      int                n_payload;
      frame.push_back(own_id_reg);
      frame.push_back($urandom_range(1) ? sender_a_reg : sender_b_reg);
      frame.push_back($urandom_range(1) ? UNICAST_ID : broadcast_reg);
      frame.push_back(BYTE_W'($urandom_range(255)));
      frame.push_back(BYTE_W'(length));
      n_payload = (length == 0) ? 1 : length;
      if (n_payload > MAX_PAYLOAD) n_payload = MAX_PAYLOAD;
      repeat (n_payload) frame.push_back(BYTE_W'($urandom_range(255)));
      if (n_payload < MAX_PAYLOAD) begin
         sum = '0;
         foreach (frame[i]) sum = sum + frame[i];
         sum = -sum;
         if (corrupt) sum = sum + BYTE_W'($urandom_range(1, 255));
         frame.push_back(sum);
      end
      foreach (frame[i]) rx_stream.push_back(frame[i]);
   endtask

   // mostly well-formed frames, some line noise and broken headers
   task automatic queue_traffic(input int words);
      int added;
      int base;
      int pick;
      int len_pick;
      added = 0;
      while (added < words) begin
         base = rx_stream.size();
         pick = $urandom_range(99);
         if (pick < 10) begin
            repeat ($urandom_range(1, 4)) rx_stream.push_back(BYTE_W'($urandom_range(255)));
         end else if (pick < 18) begin
            // start byte followed by a header that is likely to be refused
            rx_stream.push_back(own_id_reg);
            if ($urandom_range(1)) begin
               rx_stream.push_back(BYTE_W'($urandom_range(255)));
            end else begin
               rx_stream.push_back(sender_a_reg);
               rx_stream.push_back(BYTE_W'($urandom_range(255)));
            end
         end else begin
            len_pick = $urandom_range(99);
            if (len_pick < 80)      len_pick = $urandom_range(0, 8);
            else if (len_pick < 94) len_pick = $urandom_range(9, MAX_PAYLOAD - 1);
            else                    len_pick = $urandom_range(MAX_PAYLOAD, 255);
            queue_frame(len_pick, $urandom_range(99) < 15);
         end
         added += rx_stream.size() - base;
      end
   endtask

   // stimulus: settings and idle patterns phase by phase
   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: ;   // reset values
            1: begin
               csr_write(REG_OWN_ID, 8'h00);
               csr_write(REG_SENDER_ID_A, 8'h00);
               csr_write(REG_SENDER_ID_B, 8'h00);
               csr_write(REG_BROADCAST_ID, 8'h00);
            end
            2: begin
               csr_write(REG_OWN_ID, 8'hFF);
               csr_write(REG_SENDER_ID_A, 8'hFF);
               csr_write(REG_SENDER_ID_B, 8'hFF);
               csr_write(REG_BROADCAST_ID, 8'hFF);
            end
            3: begin
               csr_write(REG_OWN_ID, 8'hFF);
               csr_write(REG_SENDER_ID_A, 8'h00);
               csr_write(REG_SENDER_ID_B, 8'hFF);
               csr_write(REG_BROADCAST_ID, UNICAST_ID);
            end
            default: begin
               csr_write(REG_OWN_ID, BYTE_W'($urandom_range(255)));
               csr_write(REG_SENDER_ID_A, BYTE_W'($urandom_range(255)));
               csr_write(REG_SENDER_ID_B, BYTE_W'($urandom_range(255)));
               csr_write(REG_BROADCAST_ID,
                         $urandom_range(3) == 0 ? UNICAST_ID : BYTE_W'($urandom_range(255)));
            end
         endcase
         csr_check(REG_OWN_ID, own_id_reg);
         csr_check(REG_SENDER_ID_A, sender_a_reg);
         csr_check(REG_SENDER_ID_B, sender_b_reg);
         csr_check(REG_BROADCAST_ID, broadcast_reg);

         // none, sender gaps, receiver stalls, both
         gap_pct   = (phase % 4 == 1) ? 46 : (phase % 4 == 3) ? 24 : 0;
         stall_pct = (phase % 4 == 2) ? 46 : (phase % 4 == 3) ? 24 : 0;

         if (phase == 0) begin
            // extreme noise bytes
            rx_stream.push_back(8'h00);
            rx_stream.push_back(8'hFF);
            // zero length frame, good checksum
            queue_frame(0, 1'b0);
            // repeated start byte is refused as sender and not taken as a restart
            rx_stream.push_back(own_id_reg);
            rx_stream.push_back(own_id_reg);
            rx_stream.push_back(sender_a_reg);
            // bad target id
            rx_stream.push_back(own_id_reg);
            rx_stream.push_back(sender_b_reg);
            rx_stream.push_back(8'h02);
            // one payload byte, checksum off
            queue_frame(1, 1'b1);
            drain();
         end

         // two halves with a full drain between them
         queue_traffic(95);
         drain();
         queue_traffic(95);
         drain();
      end

      repeat (8) @(negedge clock);
      if (parsed_echoes.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", parsed_echoes.size()));

      $display("covered %0d bytes over 8 id settings and 4 idle patterns",
               words_taken);
      $display("frames: %0d good, %0d bad checksum, %0d header reject, %0d overflow",
               good_frames, bad_checksums, header_rejects, overflow_aborts);
      if (mismatch_count == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

   // watchdog, far beyond any correct run
   initial begin
      #2000000;
      $display("tb NOT OK");
      $finish;
   end

endmodule
